/* design/ssrs_pkg.sv */
`default_nettype none
package ssrs_pkg;

	localparam int MAX_RECORDS  = 4096;
	localparam int MAX_SEGMENTS = 64;
	localparam int MAX_RESULTS  = 64;

	localparam int KEY_W   = 64;
	localparam int TYPE_W  = 8;
	localparam int LABEL_W = 16;
	localparam int SIZE_W  = 13;
	localparam int STAT_W  = 2;
	localparam int ACT_W   = 2;

	localparam int REC_AW  = $clog2(MAX_RECORDS);
	localparam int REC_CW  = $clog2(MAX_RECORDS + 1);
	localparam int SEG_AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SEG_CW  = $clog2(MAX_SEGMENTS + 1);
	localparam int RES_CW  = $clog2(MAX_RESULTS + 1);
	// signed record position, wide enough for the sum of all segment sizes
	localparam int POS_W   = $clog2(MAX_SEGMENTS * (1 << SIZE_W)) + 2;

	localparam int REC_DW  = KEY_W + TYPE_W;
	localparam int SEG_DW  = SIZE_W + LABEL_W;

	localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEGMENT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RECORD  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]   kind;
		logic [KEY_W-1:0]   key;
		logic [TYPE_W-1:0]  rtype;
		logic [LABEL_W-1:0] label;
		logic [SIZE_W-1:0]  size;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic [LABEL_W-1:0] label;
		logic [TYPE_W-1:0]  rtype;
		logic [STAT_W-1:0]  status;
		logic               last;
	} res_t;

endpackage
`default_nettype wire

/* design/ssrs_ram.sv */
`default_nettype none
module ssrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* design/ssrs_front.sv */
`default_nettype none
// two-entry command queue toward the back end
module ssrs_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire ssrs_pkg::cmd_t              in_cmd,
	output logic                             q_valid,
	output ssrs_pkg::cmd_t                   q_cmd,
	input  wire logic                        q_pop
);

	ssrs_pkg::cmd_t slot_q [2];
	logic [1:0] count_q;
	logic       wr_q, rd_q;
	logic       push;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_cmd    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/ssrs_back.sv */
`default_nettype none
// store updates and the per-segment binary search with neighbor scans
module ssrs_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire ssrs_pkg::cmd_t  q_cmd,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ssrs_pkg::res_t       out_res
);

	localparam int PW = ssrs_pkg::POS_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SEG_RD = 4'd1;
	localparam logic [3:0] S_SEG_SET = 4'd2;
	localparam logic [3:0] S_PROBE  = 4'd3;
	localparam logic [3:0] S_CMP    = 4'd4;
	localparam logic [3:0] S_BK_RD  = 4'd5;
	localparam logic [3:0] S_BK_CMP = 4'd6;
	localparam logic [3:0] S_FW_RD  = 4'd7;
	localparam logic [3:0] S_FW_CMP = 4'd8;
	localparam logic [3:0] S_NEXT   = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [3:0] state_q;
	logic [ssrs_pkg::REC_CW-1:0] rec_total_q;
	logic [ssrs_pkg::SEG_CW-1:0] seg_total_q;
	logic [ssrs_pkg::SEG_CW-1:0] seg_q;
	logic [ssrs_pkg::RES_CW-1:0] n_q;
	logic [ssrs_pkg::KEY_W-1:0]  key_q;
	logic [ssrs_pkg::LABEL_W-1:0] label_q;
	logic signed [PW-1:0] lb_q, end_q, hi_q, pre_q, post_q, mid_q, p_q;
	logic [ssrs_pkg::REC_AW-1:0] raddr_q;
	ssrs_pkg::res_t pend_q;
	logic           pend_v_q;
	ssrs_pkg::res_t out_q;
	logic           out_v_q;

	// memory ports
	logic                          rec_we, seg_we;
	logic [ssrs_pkg::REC_AW-1:0]   rec_raddr;
	logic [ssrs_pkg::REC_DW-1:0]   rec_rdata;
	logic [ssrs_pkg::SEG_DW-1:0]   seg_rdata;

	ssrs_ram #(.WIDTH(ssrs_pkg::REC_DW), .DEPTH(ssrs_pkg::MAX_RECORDS)) u_rec (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_total_q[ssrs_pkg::REC_AW-1:0]),
		.wdata ({q_cmd.key, q_cmd.rtype}),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	ssrs_ram #(.WIDTH(ssrs_pkg::SEG_DW), .DEPTH(ssrs_pkg::MAX_SEGMENTS)) u_seg (
		.clk   (clk),
		.we    (seg_we),
		.waddr (seg_total_q[ssrs_pkg::SEG_AW-1:0]),
		.wdata ({q_cmd.size, q_cmd.label}),
		.raddr (seg_q[ssrs_pkg::SEG_AW-1:0]),
		.rdata (seg_rdata)
	);

	logic                         idle_take;
	logic                         out_ok;
	logic signed [PW-1:0]         top, seg_size, rb, mid_c;
	logic [PW:0]                  mid_sum;
	logic [ssrs_pkg::KEY_W-1:0]   rkey;
	logic [ssrs_pkg::TYPE_W-1:0]  rtype;
	logic                         hit_cmp, hit_bk, hit_fw, do_hit;
	logic                         trunc, hit_stall;

	assign idle_take = (state_q == S_IDLE) && q_valid;
	assign q_pop     = idle_take;
	assign rec_we    = idle_take && q_cmd.kind == ssrs_pkg::ACT_RECORD
		&& rec_total_q < ssrs_pkg::REC_CW'(ssrs_pkg::MAX_RECORDS);
	assign seg_we    = idle_take && q_cmd.kind == ssrs_pkg::ACT_SEGMENT
		&& seg_total_q < ssrs_pkg::SEG_CW'(ssrs_pkg::MAX_SEGMENTS);

	assign out_ok    = !out_v_q || out_ready;
	assign top       = PW'(rec_total_q) - PW'(1);
	assign seg_size  = PW'(seg_rdata[ssrs_pkg::SEG_DW-1 -: ssrs_pkg::SIZE_W]);
	assign rb        = lb_q + seg_size - PW'(1);
	assign mid_sum   = {pre_q[PW-1], pre_q} + {post_q[PW-1], post_q};
	assign mid_c     = mid_sum[PW:1];
	assign rkey      = rec_rdata[ssrs_pkg::REC_DW-1 -: ssrs_pkg::KEY_W];
	assign rtype     = rec_rdata[ssrs_pkg::TYPE_W-1:0];

	assign hit_cmp   = (state_q == S_CMP) && rkey == key_q;
	assign hit_bk    = (state_q == S_BK_CMP) && rkey == key_q;
	assign hit_fw    = (state_q == S_FW_CMP) && rkey == key_q;
	assign do_hit    = hit_cmp || hit_bk || hit_fw;
	assign trunc     = do_hit && n_q == ssrs_pkg::RES_CW'(ssrs_pkg::MAX_RESULTS);
	assign hit_stall = do_hit && !trunc && pend_v_q && !out_ok;

	// record read address: fresh in issuing states, held while comparing
	always_comb begin
		rec_raddr = raddr_q;
		unique case (state_q)
			S_PROBE: rec_raddr = mid_c[ssrs_pkg::REC_AW-1:0];
			S_BK_RD, S_FW_RD: rec_raddr = p_q[ssrs_pkg::REC_AW-1:0];
			default: rec_raddr = raddr_q;
		endcase
	end

	// pending result is pushed to the output register once its successor is known
	logic           push;
	ssrs_pkg::res_t push_res;
	always_comb begin
		push     = 1'b0;
		push_res = pend_q;
		if (do_hit && !trunc && pend_v_q && out_ok) begin
			push = 1'b1;
		end
		if (state_q == S_FIN && out_ok) begin
			push = 1'b1;
			if (!pend_v_q) begin
				push_res = '0;
			end
			push_res.last = 1'b1;
		end
	end

	// result word of a store action
	function automatic ssrs_pkg::res_t store_word(input logic full);
		ssrs_pkg::res_t w;
		w        = '0;
		w.status = full ? ssrs_pkg::ST_FULL : ssrs_pkg::ST_OK;
		return w;
	endfunction

	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk) begin
		raddr_q <= rec_raddr;
		if (push) begin
			out_q <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rec_total_q <= '0;
			seg_total_q <= '0;
			out_v_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			seg_q       <= '0;
			n_q         <= '0;
			key_q       <= '0;
			label_q     <= '0;
			lb_q        <= '0;
			end_q       <= '0;
			hi_q        <= '0;
			pre_q       <= '0;
			post_q      <= '0;
			mid_q       <= '0;
			p_q         <= '0;
			pend_q      <= '0;
		end else begin
			if (push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end

			if (do_hit && !trunc && !hit_stall) begin
				pend_v_q      <= 1'b1;
				pend_q.found  <= 1'b1;
				pend_q.label  <= label_q;
				pend_q.rtype  <= rtype;
				pend_q.status <= ssrs_pkg::ST_OK;
				pend_q.last   <= 1'b0;
				n_q           <= n_q + ssrs_pkg::RES_CW'(1);
			end
			if (trunc) begin
				pend_q.status <= ssrs_pkg::ST_TRUNC;
			end

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						key_q <= q_cmd.key;
						n_q   <= '0;
						seg_q <= '0;
						lb_q  <= '0;
						unique case (q_cmd.kind)
							ssrs_pkg::ACT_CLEAR: begin
								rec_total_q <= '0;
								seg_total_q <= '0;
								pend_q      <= store_word(1'b0);
								pend_v_q    <= 1'b1;
								state_q     <= S_FIN;
							end
							ssrs_pkg::ACT_SEGMENT: begin
								if (seg_we) begin
									seg_total_q <= seg_total_q + ssrs_pkg::SEG_CW'(1);
								end
								pend_q   <= store_word(!seg_we);
								pend_v_q <= 1'b1;
								state_q  <= S_FIN;
							end
							ssrs_pkg::ACT_RECORD: begin
								if (rec_we) begin
									rec_total_q <= rec_total_q + ssrs_pkg::REC_CW'(1);
								end
								pend_q   <= store_word(!rec_we);
								pend_v_q <= 1'b1;
								state_q  <= S_FIN;
							end
							default: begin
								pend_q   <= '0;
								pend_v_q <= 1'b0;
								state_q  <= (seg_total_q == '0) ? S_FIN : S_SEG_RD;
							end
						endcase
					end
				end
				S_SEG_RD: state_q <= S_SEG_SET;
				S_SEG_SET: begin
					label_q <= seg_rdata[ssrs_pkg::LABEL_W-1:0];
					end_q   <= lb_q + seg_size;
					pre_q   <= lb_q;
					hi_q    <= (rb < top) ? rb : top;
					post_q  <= (rb < top) ? rb : top;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (post_q < pre_q) begin
						state_q <= S_NEXT;
					end else begin
						mid_q   <= mid_c;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (trunc) begin
						state_q <= S_FIN;
					end else if (hit_cmp) begin
						if (!hit_stall) begin
							p_q     <= mid_q - PW'(1);
							state_q <= S_BK_RD;
						end
					end else if (key_q > rkey) begin
						pre_q   <= mid_q + PW'(1);
						state_q <= S_PROBE;
					end else begin
						post_q  <= mid_q - PW'(1);
						state_q <= S_PROBE;
					end
				end
				S_BK_RD: begin
					if (p_q >= lb_q) begin
						state_q <= S_BK_CMP;
					end else begin
						p_q     <= mid_q + PW'(1);
						state_q <= S_FW_RD;
					end
				end
				S_BK_CMP: begin
					if (trunc) begin
						state_q <= S_FIN;
					end else if (hit_bk) begin
						if (!hit_stall) begin
							p_q     <= p_q - PW'(1);
							state_q <= S_BK_RD;
						end
					end else begin
						p_q     <= mid_q + PW'(1);
						state_q <= S_FW_RD;
					end
				end
				S_FW_RD: begin
					state_q <= (p_q <= hi_q) ? S_FW_CMP : S_NEXT;
				end
				S_FW_CMP: begin
					if (trunc) begin
						state_q <= S_FIN;
					end else if (hit_fw) begin
						if (!hit_stall) begin
							p_q     <= p_q + PW'(1);
							state_q <= S_FW_RD;
						end
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					lb_q  <= end_q;
					seg_q <= seg_q + ssrs_pkg::SEG_CW'(1);
					state_q <= (seg_q + ssrs_pkg::SEG_CW'(1) >= seg_total_q) ? S_FIN : S_SEG_RD;
				end
				S_FIN: begin
					if (out_ok) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/segmented_sorted_record_search.sv */
// flow: a store action goes from S_IDLE to S_FIN, then its word to the output register;
// a query reads each segment, binary probes it, reads equal neighbors, then ends in S_FIN
// throughput: one command at a time in the back end, bound by the single read port
// of the record memory; a two-word command queue keeps the input side open
// reset: arst_n clears counters, queue and control; memory contents are undefined
// and get no clearing pass
`default_nettype none
module segmented_sorted_record_search (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,   // key_in[63:0], type_in[71:64], segment_label_in[87:72],
	                                      // segment_size_in[100:88], zero fill
	input  wire logic [1:0]   s_tuser,   // action[1:0]
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [23:0]       m_tdata,   // segment_label_out[15:0], type_out[23:16]
	output logic [2:0]        m_tuser,   // found[0], status[2:1]
	output logic              m_tlast    // final word for this command
);

	ssrs_pkg::cmd_t in_cmd, q_cmd;
	ssrs_pkg::res_t res;
	logic           q_valid, q_pop;

	// classify the incoming word into a command
	assign in_cmd.kind  = s_tuser;
	assign in_cmd.key   = s_tdata[63:0];
	assign in_cmd.rtype = s_tdata[71:64];
	assign in_cmd.label = s_tdata[87:72];
	assign in_cmd.size  = s_tdata[100:88];

	ssrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (in_cmd),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	// back end owns the memories and the result register
	ssrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.rtype, res.label};
	assign m_tuser = {res.status, res.found};
	assign m_tlast = res.last;

endmodule
`default_nettype wire

/* verif/ssrs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ssrs_checker
	import ssrs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [103:0] s_tdata,
	input  wire logic [1:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [23:0]  m_tdata,
	input  wire logic [2:0]   m_tuser,
	input  wire logic         m_tlast,
	output int                errors,
	output int                pending
);

	// shadow copy of the record store
	logic [KEY_W-1:0]   rec_key [MAX_RECORDS];
	logic [TYPE_W-1:0]  rec_type [MAX_RECORDS];
	logic [LABEL_W-1:0] seg_label [MAX_SEGMENTS];
	logic [SIZE_W-1:0]  seg_size [MAX_SEGMENTS];
	int                 rec_count;
	int                 seg_count;

	res_t expected_words[$];

	function automatic res_t make_word(logic f, logic [LABEL_W-1:0] l,
			logic [TYPE_W-1:0] t, logic [STAT_W-1:0] s, logic lst);
		res_t w;
		w.found  = f;
		w.label  = l;
		w.rtype  = t;
		w.status = s;
		w.last   = lst;
		return w;
	endfunction

	task automatic add_hit(ref res_t hits[$], ref bit stop,
			input logic [LABEL_W-1:0] l, input logic [TYPE_W-1:0] t);
		if (hits.size() >= MAX_RESULTS) begin
			hits[hits.size()-1].status = ST_TRUNC;
			stop = 1;
		end else begin
			hits = {hits, make_word(1'b1, l, t, ST_OK, 1'b0)};
		end
	endtask

	// binary search of every segment, hit then equal keys backward then forward
	task automatic predict_search(logic [KEY_W-1:0] key);
		res_t hits[$];
		bit   stop;
		int   lo, rb, hi, lb, mid, p;
		stop = 0;
		rb = -1;
		for (int j = 0; j < seg_count && !stop; j++) begin
			lb = rb + 1;
			rb = lb + int'(seg_size[j]) - 1;
			hi = (rb < rec_count - 1) ? rb : rec_count - 1;
			lo = lb;
			p  = hi;
			while (p >= lo) begin
				mid = (lo + p) / 2;
				if (key > rec_key[mid]) begin
					lo = mid + 1;
				end else if (key < rec_key[mid]) begin
					p = mid - 1;
				end else begin
					add_hit(hits, stop, seg_label[j], rec_type[mid]);
					for (int q = mid - 1; !stop && q >= lb && rec_key[q] == key; q--)
						add_hit(hits, stop, seg_label[j], rec_type[q]);
					for (int q = mid + 1; !stop && q <= hi && rec_key[q] == key; q++)
						add_hit(hits, stop, seg_label[j], rec_type[q]);
					break;
				end
			end
		end
		if (hits.size() == 0)
			hits = {hits, make_word(1'b0, '0, '0, ST_OK, 1'b0)};
		hits[hits.size()-1].last = 1'b1;
		foreach (hits[i])
			expected_words = {expected_words, hits[i]};
	endtask

	task automatic predict_word(logic [1:0] act, logic [103:0] d);
		logic [STAT_W-1:0] st;
		st = ST_OK;
		case (act)
			ACT_QUERY: begin
				predict_search(d[63:0]);
				return;
			end
			ACT_CLEAR: begin
				rec_count = 0;
				seg_count = 0;
			end
			ACT_SEGMENT: begin
				if (seg_count >= MAX_SEGMENTS) begin
					st = ST_FULL;
				end else begin
					seg_label[seg_count] = d[87:72];
					seg_size[seg_count]  = d[100:88];
					seg_count++;
				end
			end
			default: begin
				if (rec_count >= MAX_RECORDS) begin
					st = ST_FULL;
				end else begin
					rec_key[rec_count]  = d[63:0];
					rec_type[rec_count] = d[71:64];
					rec_count++;
				end
			end
		endcase
		expected_words = {expected_words, make_word(1'b0, '0, '0, st, 1'b1)};
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			rec_count = 0;
			seg_count = 0;
			errors    <= 0;
			expected_words.delete();
			pending   <= 0;
		end else begin
			// outputs first: a word accepted now never stems from the input taken now
			if (m_tvalid && m_tready) begin
				got = make_word(m_tuser[0], m_tdata[15:0], m_tdata[23:16],
					m_tuser[2:1], m_tlast);
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, actual %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_word(s_tuser, s_tdata);
			pending <= expected_words.size();
		end
	end

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import ssrs_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;  // key[63:0], type[71:64], label[87:72], size[100:88], zero fill
	logic [1:0]   s_tuser;  // action[1:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;  // label[15:0], type[23:16]
	logic [2:0]   m_tuser;  // found[0], status[2:1]
	logic         m_tlast;
	int           errors;
	int           pending;

	// gap control shared by both sides, hold request toggled for the long stall
	bit           gappy;
	bit           hold_req;
	bit           hold_seen;
	int           rx_wait;
	int           rx_draw;
	int           idle_cycles;
	int           sent;

	segmented_sorted_record_search dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	ssrs_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver: random stall per word, plus one long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_wait   <= 0;
			hold_seen <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			rx_wait   <= 400;
			m_tready  <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait  <= rx_wait - 1;
			m_tready <= 1'b0;
		end else if (m_tvalid && m_tready && gappy) begin
			rx_draw = $urandom_range(0, 10);
			if (rx_draw > 0) begin
				rx_wait  <= rx_draw - 1;
				m_tready <= 1'b0;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(logic [1:0] act, logic [63:0] key, logic [7:0] rtype,
			logic [15:0] label, logic [12:0] size);
		int gap;
		gap = gappy ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, size, label, rtype, key};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// one table: optional clear, segments, mostly sorted records with repeats, queries
	task automatic sorted_table();
		logic [63:0] keys[$];
		logic [63:0] k;
		int          nseg, total, sz;
		total = 0;
		if ($urandom_range(0, 4) != 0)
			send(ACT_CLEAR, {$urandom, $urandom}, 8'($urandom), 16'($urandom),
				13'($urandom));
		nseg = $urandom_range(1, 5);
		for (int i = 0; i < nseg; i++) begin
			sz = ($urandom_range(0, 19) == 0) ? 8191 : $urandom_range(0, 10);
			send(ACT_SEGMENT, {$urandom, $urandom}, 8'($urandom), 16'($urandom), 13'(sz));
			total += (sz > 12) ? 6 : sz;
		end
		total += $urandom_range(0, 3);
		k = {$urandom, $urandom} >> $urandom_range(0, 8);
		for (int i = 0; i < total; i++) begin
			case ($urandom_range(0, 3))
				0, 1: ;
				2: k = k + 1;
				default: k = k + {$urandom_range(0, 255), $urandom};
			endcase
			// a rare out-of-order key exercises unsorted segments
			if ($urandom_range(0, 29) == 0)
				k = {$urandom, $urandom};
			keys = {keys, k};
			send(ACT_RECORD, k, 8'($urandom), 16'($urandom), 13'($urandom));
		end
		repeat ($urandom_range(2, 8)) begin
			if (keys.size() > 0 && $urandom_range(0, 3) != 0)
				k = keys[$urandom_range(0, keys.size() - 1)];
			else
				k = {$urandom, $urandom};
			send(ACT_QUERY, k, 8'($urandom), 16'($urandom), 13'($urandom));
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_CLEAR;
		gappy    = 1'b1;
		hold_req = 1'b0;
		sent     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, empty and oversized segments
		send(ACT_QUERY, '0, '0, '0, '0);
		send(ACT_RECORD, '0, 8'h00, '0, '0);
		send(ACT_RECORD, '1, 8'hff, '1, '1);
		send(ACT_RECORD, '1, 8'h5a, '0, '0);
		send(ACT_SEGMENT, '0, '0, 16'h0000, 13'd0);
		send(ACT_SEGMENT, '0, '0, 16'hffff, 13'd3);
		send(ACT_SEGMENT, '0, '0, 16'h1234, 13'd8191);
		send(ACT_QUERY, '0, '1, '1, '1);
		send(ACT_QUERY, '1, '0, '0, '0);
		send(ACT_QUERY, 64'h8000_0000_0000_0000, '0, '0, '0);
		send(ACT_RECORD, 64'd7, 8'h11, '0, '0);
		send(ACT_RECORD, 64'd3, 8'h22, '0, '0);
		send(ACT_QUERY, 64'd7, '0, '0, '0);
		send(ACT_QUERY, 64'd3, '0, '0, '0);
		send(ACT_CLEAR, '1, '1, '1, '1);
		send(ACT_QUERY, '1, '0, '0, '0);

		// fill the segment table, overflow it, and truncate a query
		gappy = 1'b0;
		for (int i = 0; i < 70; i++)
			send(ACT_RECORD, '0, i[7:0], '0, '0);
		for (int i = 0; i <= MAX_SEGMENTS; i++)
			send(ACT_SEGMENT, '0, '0, 16'hff00 | 16'(i), 13'd64);
		send(ACT_QUERY, 64'd0, '0, '0, '0);
		send(ACT_QUERY, 64'd58, '0, '0, '0);
		send(ACT_QUERY, 64'd1000, '0, '0, '0);

		// random: long receiver hold first, then mixed gaps
		sent = 0;
		hold_req = ~hold_req;
		while (sent < 90) begin
			if (sent > 40 && sent < 60)
				gappy = 1'b0;
			else
				gappy = 1'b1;
			if ($urandom_range(0, 9) == 0)
				send(2'($urandom_range(0, 3)), {$urandom, $urandom}, 8'($urandom),
					16'($urandom), 13'($urandom_range(0, 8191)));
			else
				sorted_table();
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
